FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define MU8D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the cycle after
`define MU8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define MU8D_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define MU8D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MU8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define MU8D_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

FILE: design/mu8d_pkg.sv
// ----------------------------------------------------------------------------
// mu8d_pkg
// Types and constants of the modified UTF-8 decoder.
// ----------------------------------------------------------------------------
package mu8d_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STRAY = 2'd1;
  localparam logic [1:0] ERR_CUT   = 2'd2;

  localparam logic [7:0] MASK_ASCII = 8'h7F;
  localparam logic [7:0] MASK_CONT  = 8'h3F;
  localparam logic [7:0] MASK_LEAD2 = 8'h1F;
  localparam logic [7:0] MASK_LEAD3 = 8'h0F;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_ONE  = 2'd1,
    PEND_TWO  = 2'd2
  } pend_t;

  // one accepted byte's worth of results
  typedef struct packed {
    logic        has_unit;
    logic [15:0] unit;
    logic        unit_stray;
    logic        has_term;
    logic        term_cut;
  } cmd_t;

endpackage

FILE: design/mu8d_front.sv
// ----------------------------------------------------------------------------
// mu8d_front
// Accept bytes, track pending continuation bytes, emit result commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mu8d_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_string,
  input  logic             q_full,
  output logic             q_push,
  output mu8d_pkg::cmd_t   q_cmd
);

  mu8d_pkg::pend_t bp_r, bp_nxt, bp_dec;
  logic [15:0]     pv_r, pv_nxt, pv_dec;
  logic            acc;
  mu8d_pkg::cmd_t  cmd;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // next state
  always_comb begin
    bp_dec = mu8d_pkg::PEND_NONE;
    pv_dec = '0;
    unique case (bp_r)
      mu8d_pkg::PEND_TWO: begin
        bp_dec = mu8d_pkg::PEND_ONE;
        pv_dec = pv_r | {4'd0, in_data_byte[5:0], 6'd0};
      end
      mu8d_pkg::PEND_ONE: begin
        bp_dec = mu8d_pkg::PEND_NONE;
        pv_dec = '0;
      end
      default: begin
        if (in_data_byte[7:5] == 3'b111) begin
          bp_dec = mu8d_pkg::PEND_TWO;
          pv_dec = {in_data_byte[3:0], 12'd0};
        end else if (in_data_byte[7:6] == 2'b11) begin
          bp_dec = mu8d_pkg::PEND_ONE;
          pv_dec = {5'd0, in_data_byte[4:0], 6'd0};
        end
      end
    endcase
    bp_nxt = bp_r;
    pv_nxt = pv_r;
    if (acc) begin
      if (in_end_of_string) begin
        bp_nxt = mu8d_pkg::PEND_NONE;
        pv_nxt = '0;
      end else begin
        bp_nxt = bp_dec;
        pv_nxt = pv_dec;
      end
    end
  end

  // outputs
  always_comb begin
    cmd = '0;
    unique case (bp_r)
      mu8d_pkg::PEND_TWO: ;
      mu8d_pkg::PEND_ONE: begin
        cmd.has_unit = 1'b1;
        cmd.unit     = pv_r | {10'd0, in_data_byte[5:0]};
      end
      default: begin
        if (!in_data_byte[7]) begin
          cmd.has_unit = 1'b1;
          cmd.unit     = {8'd0, in_data_byte & mu8d_pkg::MASK_ASCII};
        end else if (in_data_byte[6] == 1'b0) begin
          cmd.has_unit   = 1'b1;
          cmd.unit_stray = 1'b1;
        end
      end
    endcase
    cmd.has_term = in_end_of_string;
    cmd.term_cut = in_end_of_string && (bp_dec != mu8d_pkg::PEND_NONE);
  end

  assign q_cmd  = cmd;
  assign q_push = acc && (cmd.has_unit || cmd.has_term);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r <= mu8d_pkg::PEND_NONE;
      pv_r <= '0;
    end else begin
      bp_r <= bp_nxt;
      pv_r <= pv_nxt;
    end
  end

  `MU8D_ASSERT_NEXT(a_eos_clears, clk, rst_n, acc && in_end_of_string,
    bp_r == mu8d_pkg::PEND_NONE && pv_r == 16'd0, "pending state survived string end")
  `MU8D_ASSERT_IMPL(a_cut_only_eos, clk, rst_n, q_push && q_cmd.term_cut,
    q_cmd.has_term && !q_cmd.has_unit, "cut flag without terminator")

endmodule

FILE: design/mu8d_queue.sv
// ----------------------------------------------------------------------------
// mu8d_queue
// Short command queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mu8d_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mu8d_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mu8d_pkg::cmd_t head_cmd
);

  mu8d_pkg::cmd_t                  mem_r [mu8d_pkg::Q_DEPTH];
  logic [mu8d_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [mu8d_pkg::Q_CNT_W-1:0]    cnt_r, cnt_nxt;

  localparam logic [mu8d_pkg::Q_PTR_W-1:0] PTR_LAST = mu8d_pkg::Q_PTR_W'(mu8d_pkg::Q_DEPTH - 1);
  localparam logic [mu8d_pkg::Q_CNT_W-1:0] CNT_FULL = mu8d_pkg::Q_CNT_W'(mu8d_pkg::Q_DEPTH);

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  `MU8D_ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
  `MU8D_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !head_valid, "pop from empty queue")

endmodule

FILE: design/mu8d_back.sv
// ----------------------------------------------------------------------------
// mu8d_back
// Expand queued commands into result beats through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mu8d_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  mu8d_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [15:0]    out_code_unit,
  output logic           out_is_terminator,
  output logic [1:0]     out_error_kind,
  output logic           out_last
);

  logic        out_valid_r, out_valid_nxt;
  logic        unit_done_r, unit_done_nxt;
  logic [15:0] code_r, code_nxt;
  logic        term_r, term_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        last_r, last_nxt;
  logic        load, emit_unit;

  assign load      = head_valid && (!out_valid_r || out_ready);
  assign emit_unit = head_cmd.has_unit && !unit_done_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    unit_done_nxt = unit_done_r;
    code_nxt      = code_r;
    term_nxt      = term_r;
    err_nxt       = err_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (emit_unit) begin
        code_nxt      = head_cmd.unit;
        term_nxt      = 1'b0;
        err_nxt       = head_cmd.unit_stray ? mu8d_pkg::ERR_STRAY : mu8d_pkg::ERR_NONE;
        last_nxt      = 1'b0;
        pop           = !head_cmd.has_term;
        unit_done_nxt = head_cmd.has_term;
      end else begin
        code_nxt      = '0;
        term_nxt      = 1'b1;
        err_nxt       = head_cmd.term_cut ? mu8d_pkg::ERR_CUT : mu8d_pkg::ERR_NONE;
        last_nxt      = 1'b1;
        pop           = 1'b1;
        unit_done_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      unit_done_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unit_done_r <= unit_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    term_r <= term_nxt;
    err_r  <= err_nxt;
    last_r <= last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_code_unit     = code_r;
  assign out_is_terminator = term_r;
  assign out_error_kind    = err_r;
  assign out_last          = last_r;

  `MU8D_ASSERT_IMPL(a_split_head, clk, rst_n, unit_done_r,
    head_valid && head_cmd.has_unit && head_cmd.has_term, "split command lost its head")
  `MU8D_ASSERT_NEXT(a_unit_then_term, clk, rst_n, load && emit_unit && head_cmd.has_term,
    unit_done_r, "terminator half of command not held")

endmodule

FILE: design/modified_utf8_char_decoder.sv
// ----------------------------------------------------------------------------
// modified_utf8_char_decoder
// Java modified UTF-8 byte stream to 16-bit code units, with terminator.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    data_byte[7:0], end_of_string
//   out_     out  out_valid / out_ready  code_unit[15:0], is_terminator,
//                                        error_kind[1:0], last
//
// One byte is taken per cycle while the four-entry command queue has room.
// A result passes through the queue, then the output register; a byte
// yielding a unit and a terminator uses the output register for both,
// unit first. Reset clears the pending count and the queue.
// The queue decouples output stalls from input acceptance.
// ----------------------------------------------------------------------------
module modified_utf8_char_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_is_terminator,
  output logic [1:0]  out_error_kind,
  output logic        out_last
);

  logic           q_full, q_push, q_pop, q_head_valid;
  mu8d_pkg::cmd_t q_cmd, q_head;

  mu8d_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  mu8d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head)
  );

  mu8d_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head_cmd          (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_code_unit     (out_code_unit),
    .out_is_terminator (out_is_terminator),
    .out_error_kind    (out_error_kind),
    .out_last          (out_last)
  );

endmodule
